@@ hw/rtl/lazy_min_priority_queue_unit_defines.svh @@
// ----------------------------------------------------------------------------
// lazy_min_priority_queue_unit_defines.svh
// Assertion macros used by the checker file of the queue unit.
// ----------------------------------------------------------------------------
`ifndef LAZY_MIN_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define LAZY_MIN_PRIORITY_QUEUE_UNIT_DEFINES_SVH

// property holds at every rising clock edge outside reset
`define LMPQ_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("%m: assertion failed");

// condition never true outside reset
`define LMPQ_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("%m: forbidden condition seen");

`endif

@@ hw/rtl/lmpq_pkg.sv @@
// ----------------------------------------------------------------------------
// lmpq_pkg
// Types and codes shared by the lazy min-priority queue modules.
// ----------------------------------------------------------------------------
package lmpq_pkg;

  localparam int unsigned NODE_BITS   = 8;
  localparam int unsigned CMD_BITS    = 2;
  localparam int unsigned STATUS_BITS = 2;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_POP    = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_BITS-1:0] {
    STS_OK      = 2'd0,
    STS_EMPTY   = 2'd1,
    STS_IGNORED = 2'd2,
    STS_FULL    = 2'd3
  } status_e;

  // control broadcast to every cell of the chain
  typedef struct packed {
    logic clear;
    logic insert;
    logic pop;
  } cell_ctrl_t;

endpackage

@@ hw/rtl/lmpq_ram.sv @@
// ----------------------------------------------------------------------------
// lmpq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lmpq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/lmpq_cell.sv @@
// ----------------------------------------------------------------------------
// lmpq_cell
// One slot of the sorted shift chain: holds a (node, key) entry, takes part
// in sorted insertion and shifts toward the head on pop.
// ----------------------------------------------------------------------------
module lmpq_cell import lmpq_pkg::*; #(
  parameter int unsigned KEY_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cell_ctrl_t           ctrl_i,
  input  logic [NODE_BITS-1:0] new_node_i,
  input  logic [KEY_BITS-1:0]  new_key_i,
  input  logic [NODE_BITS-1:0] prev_node_i,
  input  logic [KEY_BITS-1:0]  prev_key_i,
  input  logic                 prev_valid_i,
  input  logic                 prev_lt_i,
  input  logic [NODE_BITS-1:0] next_node_i,
  input  logic [KEY_BITS-1:0]  next_key_i,
  input  logic                 next_valid_i,
  output logic [NODE_BITS-1:0] node_o,
  output logic [KEY_BITS-1:0]  key_o,
  output logic                 valid_o,
  output logic                 lt_o
);

  logic [NODE_BITS-1:0] node_q, node_d;
  logic [KEY_BITS-1:0]  key_q, key_d;
  logic                 valid_q, valid_d;
  logic                 key_lt, key_eq;

  assign key_lt = $signed(new_key_i) < $signed(key_q);
  assign key_eq = new_key_i == key_q;
  // empty slots count as +infinity
  assign lt_o   = !valid_q || key_lt || (key_eq && (new_node_i < node_q));

  always_comb begin
    node_d  = node_q;
    key_d   = key_q;
    valid_d = valid_q;
    if (ctrl_i.clear) begin
      valid_d = 1'b0;
    end else if (ctrl_i.pop) begin
      node_d  = next_node_i;
      key_d   = next_key_i;
      valid_d = next_valid_i;
    end else if (ctrl_i.insert && lt_o) begin
      if (prev_lt_i) begin
        node_d  = prev_node_i;
        key_d   = prev_key_i;
        valid_d = prev_valid_i;
      end else begin
        node_d  = new_node_i;
        key_d   = new_key_i;
        valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    node_q <= node_d;
    key_q  <= key_d;
  end

  assign node_o  = node_q;
  assign key_o   = key_q;
  assign valid_o = valid_q;

endmodule

@@ hw/rtl/lazy_min_priority_queue_unit.sv @@
// Clear and unused commands finish from idle; insert reads the key RAM, then decides;
// pop removes stale entries and the one it returns, or stops when the chain is empty.
// Throughput: one command at a time; busy_o is high from transfer to result,
//   never for clear or an unused command. Pop sheds one chain entry per cycle.
// Reset (rst_ni low, async) empties the chain and clears all node marks.
// Results appear for one cycle on done_o; the receiver cannot stall.
// ----------------------------------------------------------------------------
// lazy_min_priority_queue_unit
// Min-priority queue of node ids with lazy deletion. Entries sit in a sorted
// chain of cells (head = smallest (key, node)); a per-node mark bit and a
// key RAM decide whether an insert is taken, and the mark bit decides whether a
// popped entry is still live.
// ----------------------------------------------------------------------------
module lazy_min_priority_queue_unit import lmpq_pkg::*; #(
  parameter int unsigned NODE_COUNT = 256,
  parameter int unsigned HEAP_DEPTH = 1024,
  parameter int unsigned KEY_BITS   = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  output logic                   busy_o,
  input  logic [CMD_BITS-1:0]    command_i,
  input  logic [NODE_BITS-1:0]   node_id_i,
  input  logic [KEY_BITS-1:0]    key_value_i,
  output logic                   done_o,
  output logic [NODE_BITS-1:0]   popped_node_o,
  output logic [STATUS_BITS-1:0] status_o
);

  localparam int unsigned NodeIdxW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int unsigned CntW     = $clog2(HEAP_DEPTH + 1);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_INS_RD = 4'b0010,
    ST_INS_DO = 4'b0100,
    ST_POP    = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // latched command
  logic [CMD_BITS-1:0]  cmd_q;
  logic [NODE_BITS-1:0] node_q;
  logic [KEY_BITS-1:0]  key_q;

  logic [CntW-1:0]       count_q, count_d;
  logic [NODE_COUNT-1:0] marks_q, marks_d;

  logic                   done_q, done_d;
  logic [NODE_BITS-1:0]   popped_q, popped_d;
  logic [STATUS_BITS-1:0] status_q, status_d;

  logic accept;
  assign accept = start_i && (state_q == ST_IDLE);
  assign busy_o = state_q != ST_IDLE;

  // key RAM: recorded key per node
  logic [NodeIdxW-1:0] node_idx;
  logic [KEY_BITS-1:0] rec_key;
  logic                key_we;
  assign node_idx = NodeIdxW'(node_q);

  lmpq_ram #(
    .WIDTH (KEY_BITS),
    .DEPTH (NODE_COUNT)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (node_idx),
    .wdata_i (key_q),
    .raddr_i (node_idx),
    .rdata_o (rec_key)
  );

  // cell chain
  cell_ctrl_t           ctrl;
  logic [NODE_BITS-1:0] c_node  [HEAP_DEPTH];
  logic [KEY_BITS-1:0]  c_key   [HEAP_DEPTH];
  logic                 c_valid [HEAP_DEPTH];
  logic                 c_lt    [HEAP_DEPTH];

  for (genvar i = 0; i < HEAP_DEPTH; i++) begin : g_cell
    logic [NODE_BITS-1:0] p_node, n_node;
    logic [KEY_BITS-1:0]  p_key, n_key;
    logic                 p_valid, p_lt, n_valid;

    if (i == 0) begin : g_head
      assign p_node  = node_q;
      assign p_key   = key_q;
      assign p_valid = 1'b0;
      assign p_lt    = 1'b0;
    end else begin : g_mid
      assign p_node  = c_node[i-1];
      assign p_key   = c_key[i-1];
      assign p_valid = c_valid[i-1];
      assign p_lt    = c_lt[i-1];
    end

    if (i == HEAP_DEPTH - 1) begin : g_tail
      assign n_node  = node_q;
      assign n_key   = key_q;
      assign n_valid = 1'b0;
    end else begin : g_body
      assign n_node  = c_node[i+1];
      assign n_key   = c_key[i+1];
      assign n_valid = c_valid[i+1];
    end

    lmpq_cell #(
      .KEY_BITS (KEY_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .new_node_i   (node_q),
      .new_key_i    (key_q),
      .prev_node_i  (p_node),
      .prev_key_i   (p_key),
      .prev_valid_i (p_valid),
      .prev_lt_i    (p_lt),
      .next_node_i  (n_node),
      .next_key_i   (n_key),
      .next_valid_i (n_valid),
      .node_o       (c_node[i]),
      .key_o        (c_key[i]),
      .valid_o      (c_valid[i]),
      .lt_o         (c_lt[i])
    );
  end

  // insert decision
  logic in_range, stale_ins, full;
  logic [NodeIdxW-1:0] head_idx;
  assign in_range  = 32'(node_q) < NODE_COUNT;
  assign stale_ins = marks_q[node_idx] && ($signed(key_q) > $signed(rec_key));
  assign full      = count_q == CntW'(HEAP_DEPTH);
  assign head_idx  = NodeIdxW'(c_node[0]);

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    marks_d  = marks_q;
    done_d   = 1'b0;
    popped_d = '0;
    status_d = STS_OK;
    ctrl     = '0;
    key_we   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (command_i)
            CMD_CLEAR: begin
              ctrl.clear = 1'b1;
              count_d    = '0;
              marks_d    = '0;
              done_d     = 1'b1;
            end
            CMD_INSERT: state_d = ST_INS_RD;
            CMD_POP:    state_d = ST_POP;
            default:    done_d  = 1'b1;
          endcase
        end
      end
      ST_INS_RD: state_d = ST_INS_DO;
      ST_INS_DO: begin
        state_d = ST_IDLE;
        done_d  = 1'b1;
        if (!in_range || stale_ins) begin
          status_d = STS_IGNORED;
        end else if (full) begin
          status_d = STS_FULL;
        end else begin
          ctrl.insert       = 1'b1;
          key_we            = 1'b1;
          marks_d[node_idx] = 1'b1;
          count_d           = count_q + 1'b1;
        end
      end
      ST_POP: begin
        if (count_q == '0) begin
          state_d  = ST_IDLE;
          done_d   = 1'b1;
          status_d = STS_EMPTY;
        end else begin
          ctrl.pop = 1'b1;
          count_d  = count_q - 1'b1;
          // stale entries are dropped and the walk continues
          if (marks_q[head_idx]) begin
            marks_d[head_idx] = 1'b0;
            state_d           = ST_IDLE;
            done_d            = 1'b1;
            popped_d          = c_node[0];
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      marks_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      marks_q <= marks_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    popped_q <= popped_d;
    status_q <= status_d;
    if (accept) begin
      cmd_q  <= command_i;
      node_q <= node_id_i;
      key_q  <= key_value_i;
    end
  end

  assign done_o        = done_q;
  assign popped_node_o = (cmd_q == CMD_POP) ? popped_q : popped_q & '0;
  assign status_o      = status_q;

endmodule

@@ hw/rtl/lmpq_checker.sv @@
// ----------------------------------------------------------------------------
// lmpq_checker
// Port-level checks of the queue unit's command and result behavior.
// ----------------------------------------------------------------------------
`include "lazy_min_priority_queue_unit_defines.svh"

module lmpq_checker import lmpq_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   start_i,
  input logic                   busy_o,
  input logic                   done_o,
  input logic [NODE_BITS-1:0]   popped_node_o,
  input logic [STATUS_BITS-1:0] status_o
);

  `LMPQ_ASSERT(a_accept_busy, clk_i, rst_ni, (start_i && !busy_o) |=> (busy_o || done_o))
  `LMPQ_ASSERT(a_accept_no_done, clk_i, rst_ni, (start_i && !busy_o) |=> !(done_o && busy_o))
  `LMPQ_NEVER(a_done_while_busy, clk_i, rst_ni, done_o && busy_o)
  `LMPQ_ASSERT(a_node_only_ok, clk_i, rst_ni, (done_o && status_o != STS_OK) |-> popped_node_o == '0)
  `LMPQ_ASSERT(a_done_after_busy, clk_i, rst_ni, ($fell(busy_o)) |-> done_o)

endmodule

bind lazy_min_priority_queue_unit lmpq_checker u_lmpq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start_i       (start_i),
  .busy_o        (busy_o),
  .done_o        (done_o),
  .popped_node_o (popped_node_o),
  .status_o      (status_o)
);
